### sv/lzwsc_pkg.sv
// Package for the LZW stream compressor: special codes and word geometry.
// No dependencies.
`timescale 1ns / 1ps

package lzwsc_pkg;

  // Special codes and first free dictionary code
  localparam logic [8:0] CODE_CLEAR = 9'd256;
  localparam logic [8:0] CODE_END   = 9'd257;
  localparam logic [8:0] FIRST_FREE = 9'd258;

  // Code width after a dictionary clear
  localparam logic [4:0] START_BITS = 5'd9;

  // Packed output word
  localparam int WORD_W = 32;
  typedef logic [WORD_W-1:0] word_t;

endpackage

### sv/lzw_stream_compressor.sv
// LZW compressor with variable width codes packed MSB first into 32-bit words.
// Depends on lzwsc_pkg.
`timescale 1ns / 1ps

//  channel | handshake           | payload
//  --------+---------------------+-------------------------------
//  input   | in_valid, in_stall  | in_byte[7:0], is_last
//  output  | out_valid, out_stall| out_word[31:0], word_last
//
// One item at a time: an accept step, then per table probe a table read and, if the
// slot may be live, a dictionary read; a hit then goes on to the tail step.
// A miss adds a code put (split in two across a word boundary) and an insert step, or
// a clear code put and a clear step when full; a last item adds two puts and a flush.
// Each word sent adds a step that waits on out_stall in the single output register.
// Synchronous reset; no memory clearing: a slot counts only while its code is live.
module lzw_stream_compressor import lzwsc_pkg::*; #(
  parameter int MAX_CODE_BITS = 12,
  parameter int TABLE_DEPTH   = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output word_t       out_word,
  output logic        word_last
);

  localparam int CW    = MAX_CODE_BITS;
  localparam int NC_W  = CW + 1;
  localparam int KEY_W = CW + 8;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDT  = 4'd1;
  localparam logic [3:0] S_RDD  = 4'd2;
  localparam logic [3:0] S_PUT  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_TAIL = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;
  localparam logic [3:0] S_FLSH = 4'd8;

  // Memories: match table {key, code} by hash, dictionary key by code
  logic [KEY_W+CW-1:0] table_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]    dict_mem  [1 << CW];

  logic [3:0]          state;
  logic [3:0]          ret;
  logic                started;
  logic [CW-1:0]       cur;
  logic [NC_W-1:0]     next_code;
  logic [4:0]          code_width;
  word_t               buf_w;
  logic [5:0]          fill;
  logic [7:0]          b;
  logic                last;
  logic [IDX_W-1:0]    idx;
  logic [CW-1:0]       pc;
  logic [4:0]          pw;

  logic                t_rd, d_rd, t_wr;
  logic [IDX_W-1:0]    t_addr;
  logic [CW-1:0]       d_addr;
  logic [KEY_W+CW-1:0] t_q;
  logic [KEY_W-1:0]    d_q;

  logic [KEY_W-1:0]    key;
  logic [IDX_W-1:0]    hash_idx;
  logic [KEY_W-1:0]    e_key;
  logic [CW-1:0]       e_code;
  logic                in_range;
  logic                out_free;
  logic                word_go;
  logic [CW:0]         one_sh;
  logic [CW-1:0]       pcm;
  logic [5:0]          room;
  logic [5:0]          lsh;
  logic [4:0]          rsh;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  // A word is loaded into the output register this cycle
  assign word_go  = out_free && ((state == S_FLSH) || (state == S_PUT && fill == 6'd32));

  // Key and hash of the current prefix and byte
  assign key      = {cur, b};
  assign hash_idx = IDX_W'(({24'd0, b} << 5) ^ 32'(cur) ^ (32'(cur) >> 7));
  assign e_key    = t_q[KEY_W+CW-1:CW];
  assign e_code   = t_q[CW-1:0];
  assign in_range = (e_code >= CW'(FIRST_FREE)) && (NC_W'(e_code) < next_code);

  // Bit packing helpers
  assign one_sh = (CW+1)'(1) << pw;
  assign pcm    = pc & one_sh[CW-1:0] - CW'(1) | (pc & {CW{one_sh[CW]}});
  assign room   = 6'd32 - fill;
  assign lsh    = room - 6'(pw);
  assign rsh    = pw - room[4:0];

  // Table and dictionary ports
  assign t_addr = (state == S_RDD) ? idx + IDX_W'(1) : hash_idx;
  assign t_rd   = ((state == S_RDD) && (d_q == e_key) && in_range && (e_key != key))
                  || (state == S_TAIL && 1'b0);
  assign d_addr = (state == S_ADD) ? next_code[CW-1:0] : e_code;
  assign d_rd   = (state == S_RDT);
  assign t_wr   = (state == S_ADD) && (next_code != (NC_W'(1) << CW));

  always_ff @(posedge clk) begin
    if (t_wr) begin
      table_mem[idx] <= {key, next_code[CW-1:0]};
      dict_mem[next_code[CW-1:0]] <= key;
    end
    if ((state == S_IDLE && in_valid && started) || t_rd) begin
      t_q <= table_mem[(state == S_IDLE) ? IDX_W'(({24'd0, in_byte} << 5) ^ 32'(cur)
                       ^ (32'(cur) >> 7)) : t_addr];
    end
    if (d_rd) begin
      d_q <= dict_mem[d_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      started    <= 1'b0;
      cur        <= '0;
      next_code  <= NC_W'(FIRST_FREE);
      code_width <= START_BITS;
      buf_w      <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
      word_last  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !word_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            b    <= in_byte;
            last <= is_last;
            if (!started) begin
              next_code  <= NC_W'(FIRST_FREE);
              code_width <= START_BITS;
              buf_w      <= '0;
              fill       <= '0;
              cur        <= CW'(in_byte);
              started    <= 1'b1;
              pc         <= CW'(CODE_CLEAR);
              pw         <= START_BITS;
              ret        <= S_TAIL;
              state      <= S_PUT;
            end else begin
              idx   <= IDX_W'(({24'd0, in_byte} << 5) ^ 32'(cur) ^ (32'(cur) >> 7));
              state <= S_RDT;
            end
          end
        end
        S_RDT: begin
          if (in_range) begin
            state <= S_RDD;
          end else begin
            pc    <= cur;
            pw    <= code_width;
            ret   <= S_ADD;
            state <= S_PUT;
          end
        end
        S_RDD: begin
          if (d_q == e_key && e_key == key) begin
            cur   <= e_code;
            state <= S_TAIL;
          end else if (d_q == e_key) begin
            idx   <= idx + IDX_W'(1);
            state <= S_RDT;
          end else begin
            pc    <= cur;
            pw    <= code_width;
            ret   <= S_ADD;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (fill == 6'd32) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_word  <= buf_w;
              word_last <= 1'b0;
              buf_w     <= '0;
              fill      <= '0;
            end
          end else if (6'(pw) <= room) begin
            buf_w <= buf_w | (word_t'(pcm) << lsh);
            fill  <= fill + 6'(pw);
            state <= ret;
          end else begin
            buf_w <= buf_w | (word_t'(pcm) >> rsh);
            fill  <= 6'd32;
            pw    <= rsh;
          end
        end
        S_ADD: begin
          if (next_code == (NC_W'(1) << CW)) begin
            pc    <= CW'(CODE_CLEAR);
            pw    <= code_width;
            ret   <= S_CLR;
            state <= S_PUT;
          end else begin
            next_code <= next_code + NC_W'(1);
            if ((next_code + NC_W'(1)) == (NC_W'(1) << code_width)
                && code_width < 5'(CW)) begin
              code_width <= code_width + 5'd1;
            end
            cur   <= CW'(b);
            state <= S_TAIL;
          end
        end
        S_CLR: begin
          next_code  <= NC_W'(FIRST_FREE);
          code_width <= START_BITS;
          cur        <= CW'(b);
          state      <= S_TAIL;
        end
        S_TAIL: begin
          if (last) begin
            pc    <= cur;
            pw    <= code_width;
            ret   <= S_END;
            state <= S_PUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_END: begin
          pc    <= CW'(CODE_END);
          pw    <= code_width;
          ret   <= S_FLSH;
          state <= S_PUT;
        end
        S_FLSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= buf_w;
            word_last <= 1'b1;
            buf_w     <= '0;
            fill      <= '0;
            started   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for lzw_stream_compressor: predicts packed LZW words.
// Depends on lzwsc_pkg and the lzw_stream_compressor RTL.
`timescale 1ns / 1ps

// Scoreboard: holds its own LZW dictionary and bit packer, and the expected words
class lzw_scoreboard;
  bit [11:0] dict_code [bit [19:0]];   // (prefix, byte) -> code
  bit [11:0] cur_code;
  bit [12:0] free_code;
  int        width;
  bit [31:0] acc_word;
  int        bit_pos;
  bit        in_stream;
  bit [32:0] pending_words [$];
  int        errors;
  int        words_seen;
  int        streams;

  function new();
    dict_clear();
    cur_code  = 0;
    acc_word  = 0;
    bit_pos   = 31;
    in_stream = 0;
    errors    = 0;
    words_seen = 0;
    streams   = 0;
  endfunction

  function void dict_clear();
    dict_code.delete();
    free_code = 13'(lzwsc_pkg::FIRST_FREE);
    width     = int'(lzwsc_pkg::START_BITS);
  endfunction

  // Append a code MSB first; a full word leaves only when another bit arrives
  function void pack_code(int code, int w);
    for (int i = w - 1; i >= 0; i--) begin
      if (bit_pos < 0) begin
        pending_words.push_back({1'b0, acc_word});
        acc_word = 0;
        bit_pos  = 31;
      end
      if ((code >> i) & 1) acc_word[bit_pos] = 1'b1;
      bit_pos--;
    end
  endfunction

  // Note an accepted input item and queue the words it yields
  function void note_byte(bit [7:0] b, bit last);
    bit [19:0] key;
    key = {cur_code, b};
    if (!in_stream) begin
      dict_clear();
      acc_word = 0;
      bit_pos  = 31;
      pack_code(int'(lzwsc_pkg::CODE_CLEAR), width);
      cur_code  = 12'(b);
      in_stream = 1;
    end else if (dict_code.exists(key)) begin
      cur_code = dict_code[key];
    end else begin
      pack_code(int'(cur_code), width);
      if (free_code == 13'd4096) begin
        // dictionary full: clear instead of adding
        pack_code(int'(lzwsc_pkg::CODE_CLEAR), width);
        dict_clear();
      end else begin
        dict_code[key] = free_code[11:0];
        free_code++;
        if (free_code == (13'd1 << width) && width < 12) width++;
      end
      cur_code = 12'(b);
    end
    if (last) begin
      pack_code(int'(cur_code), width);
      pack_code(int'(lzwsc_pkg::CODE_END), width);
      pending_words.push_back({1'b1, acc_word});
      acc_word  = 0;
      bit_pos   = 31;
      in_stream = 0;
      streams++;
    end
  endfunction

  // Check an accepted result item against the oldest expectation
  function void check_word(bit [31:0] w, bit last);
    bit [32:0] exp_w;
    words_seen++;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word %h last %0d", $time, w, last);
      errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    if (exp_w[31:0] !== w) begin
      $display("%0t: out_word expected %h actual %h", $time, exp_w[31:0], w);
      errors++;
    end
    if (exp_w[32] !== last) begin
      $display("%0t: word_last expected %0d actual %0d", $time, exp_w[32], last);
      errors++;
    end
  endfunction
endclass

module testbench import lzwsc_pkg::*; ();

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  word_t       out_word;
  logic        word_last;

  lzw_scoreboard sb;
  int  idle_cycles;
  int  bytes_sent;
  int  stall_hold;
  bit  stall_free;

  lzw_stream_compressor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .word_last(word_last)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Mostly short gaps, a few long ones, some stretches with none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until accepted; valid stays up into the next call
  task automatic send_byte(input bit [7:0] b, input bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    is_last  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Stream of random bytes from a small alphabet so that matches grow long
  task automatic send_stream(input int len, input int alpha);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, alpha - 1)), i == len - 1);
  endtask

  // Output side: random stall with occasional long holds, check on acceptance
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_word(out_word, word_last);
      if (stall_free) begin
        out_stall  <= 1'b0;
        stall_hold <= 0;
      end else if (stall_hold > 0) begin
        out_stall  <= 1'b1;
        stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(8, 40);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    is_last = 1'b0;
    stall_free = 1'b0;
    bytes_sent = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-byte streams at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Repeats hit the dictionary, then a mixed short stream
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'(i * 23), i == 11);
    // Pause the sender until every word is back
    wait_drained();

    // Long stream of mostly distinct pairs: code width grows past 9 bits
    for (int i = 0; i < 300; i++) send_byte(8'($urandom_range(0, 255)), i == 299);
    stall_free = 1'b1;
    wait_drained();
    stall_free = 1'b0;

    // Random streams, mostly short, varied alphabets
    while (bytes_sent < 470) begin
      send_stream($urandom_range(1, 30), $urandom_range(0, 3) == 0 ? 256 :
                  $urandom_range(2, 8));
      if ($urandom_range(0, 9) == 0) stall_free = ~stall_free;
    end
    stall_free = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Ran %0d bytes in %0d streams, checked %0d words,", bytes_sent, sb.streams,
             sb.words_seen);
    $display("including single-byte streams and code width growth to 10 bits.");
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### lzw_stream_compressor.f
sv/lzwsc_pkg.sv
sv/lzw_stream_compressor.sv
verif/testbench.sv
